[sv/mtem_pkg.sv]
// mtem_pkg: shared types and constants for the multi timer expiry manager
// no dependencies; used by every module of the block
package mtem_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int COUNT_BITS = 16;
    localparam int TIME_W     = 32;
    localparam int DIV_CNT_W  = $clog2(TIME_W);
    localparam int FIFO_DEPTH = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [TIME_W:0]   CNT_MAX  = 33'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum logic [1:0] {
        OP_SERVICE = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_CHANGE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_DIV,
        S_RELOAD,
        S_EMIT,
        S_POST,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  timer_id;
        logic [31:0] new_period;
        logic [31:0] time_now;
    } t_in;

    typedef struct packed {
        logic [2:0]  fired_timer;
        logic [15:0] fire_count;
        logic        last_event;
    } t_out;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] id;
        logic             id_ok;
        logic [31:0]      period;
        logic [31:0]      time_now;
    } t_cmd;

endpackage

[sv/mtem_front.sv]
// mtem_front: accepts requests and decodes them into queued commands
// depends on mtem_pkg
module mtem_front (
    input  logic            i_valid,
    output logic            o_stall,
    input  mtem_pkg::t_in   i_in,
    input  logic            i_full,
    output logic            o_push,
    output mtem_pkg::t_cmd  o_cmd
);

    always_comb begin
        o_stall        = i_full;
        o_push         = i_valid && !i_full;
        o_cmd.op       = mtem_pkg::t_op'(i_in.mode);
        o_cmd.id       = mtem_pkg::IDX_W'(i_in.timer_id);
        o_cmd.id_ok    = 32'(i_in.timer_id) < mtem_pkg::NUM_TIMERS;
        o_cmd.period   = (i_in.new_period == '0) ? 32'd1 : i_in.new_period;
        o_cmd.time_now = i_in.time_now;
    end

endmodule

[sv/mtem_fifo.sv]
// mtem_fifo: short command queue between the front and the timer engine
// depends on mtem_pkg
module mtem_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtem_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mtem_pkg::t_cmd  o_cmd
);

    mtem_pkg::t_cmd r_mem [mtem_pkg::FIFO_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'(mtem_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[sv/mtem_back.sv]
// mtem_back: timer state, earliest-expiry scan, reload divider and result output
// depends on mtem_pkg
module mtem_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_empty,
    input  mtem_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output mtem_pkg::t_out  o_out
);

    localparam int N  = mtem_pkg::NUM_TIMERS;
    localparam int IW = mtem_pkg::IDX_W;

    mtem_pkg::t_state r_state, n_state;

    logic [7:0]                     r_mask;
    logic [31:0]                    r_period [N];
    logic [31:0]                    r_expiry [N];
    logic [N-1:0]                   r_armed;
    logic [N-1:0]                   r_next;
    logic [31:0]                    r_prev;
    mtem_pkg::t_cmd                 r_cmd;
    logic                           r_wrap;
    logic [31:0]                    r_now;
    logic [IW-1:0]                  r_idx;
    logic                           r_found;
    logic [IW-1:0]                  r_best;
    logic [31:0]                    r_best_exp;
    logic [IW-1:0]                  r_sel;
    logic [mtem_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic [31:0]                    r_rem;
    logic [31:0]                    r_quo;
    logic [IW-1:0]                  r_new_id;
    logic [15:0]                    r_new_cnt;
    logic                           r_hold_v;
    logic [IW-1:0]                  r_hold_id;
    logic [15:0]                    r_hold_cnt;
    logic                           r_o_valid;
    mtem_pkg::t_out                 r_o;

    logic        out_free;
    logic        out_load;
    logic        wrap_now;
    logic        elig;
    logic        better;
    logic        due;
    logic        sel_reload;
    logic [31:0] sel_period;
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] reload_sum;
    logic [32:0] quo_inc;
    logic [15:0] sat_cnt;
    logic        arm_go;
    logic [31:0] arm_period;
    logic [32:0] arm_sum;

    always_comb begin
        out_free   = !r_o_valid || !i_stall;
        out_load   = r_hold_v && out_free
                     && (r_state == mtem_pkg::S_EMIT || r_state == mtem_pkg::S_FINISH);
        wrap_now   = i_cmd.time_now < r_prev;
        elig       = r_armed[r_idx] && !r_next[r_idx];
        better     = !r_found || (r_expiry[r_idx] < r_best_exp);
        due        = r_found && (r_wrap || (r_best_exp <= r_now));
        sel_reload = (32'(r_best) < 32'd8) && r_mask[3'(r_best)];
        sel_period = r_period[r_sel];
        div_t      = {r_rem, r_quo[31]};
        div_ge     = div_t >= {1'b0, sel_period};
        reload_sum = {1'b0, r_now - r_rem} + {1'b0, sel_period};
        quo_inc    = {1'b0, r_quo} + 33'd1;
        sat_cnt    = (quo_inc > mtem_pkg::CNT_MAX) ? mtem_pkg::CNT_MAX[15:0] : quo_inc[15:0];
        arm_go     = (r_cmd.op == mtem_pkg::OP_START || r_cmd.op == mtem_pkg::OP_CHANGE)
                     && r_cmd.id_ok;
        arm_period = (r_cmd.op == mtem_pkg::OP_CHANGE) ? r_cmd.period : sel_period;
        arm_sum    = {1'b0, r_cmd.time_now} + {1'b0, arm_period};
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            mtem_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == mtem_pkg::OP_STOP) begin
                        n_state = mtem_pkg::S_IDLE;
                    end else if (wrap_now || i_cmd.op == mtem_pkg::OP_SERVICE) begin
                        n_state = mtem_pkg::S_SCAN;
                    end else begin
                        n_state = mtem_pkg::S_POST;
                    end
                end
            end
            mtem_pkg::S_SCAN: begin
                if (32'(r_idx) == N - 1) begin
                    n_state = mtem_pkg::S_PICK;
                end
            end
            mtem_pkg::S_PICK: begin
                if (due) begin
                    n_state = sel_reload ? mtem_pkg::S_DIV : mtem_pkg::S_EMIT;
                end else if (r_wrap) begin
                    n_state = mtem_pkg::S_POST;
                end else begin
                    n_state = mtem_pkg::S_FINISH;
                end
            end
            mtem_pkg::S_DIV: begin
                if (r_dcnt == '1) begin
                    n_state = mtem_pkg::S_RELOAD;
                end
            end
            mtem_pkg::S_RELOAD: begin
                n_state = mtem_pkg::S_EMIT;
            end
            mtem_pkg::S_EMIT: begin
                if (!r_hold_v || out_free) begin
                    n_state = r_wrap ? mtem_pkg::S_SCAN : mtem_pkg::S_FINISH;
                end
            end
            mtem_pkg::S_POST: begin
                n_state = mtem_pkg::S_FINISH;
            end
            mtem_pkg::S_FINISH: begin
                if (!r_hold_v || out_free) begin
                    n_state = mtem_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtem_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtem_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_armed   <= '0;
            r_next    <= '0;
            r_prev    <= '0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_period[i] <= 32'd1;
                r_expiry[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                mtem_pkg::S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_sel   <= i_cmd.id;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (i_cmd.op == mtem_pkg::OP_STOP) begin
                            if (i_cmd.id_ok) begin
                                r_armed[i_cmd.id] <= 1'b0;
                                r_next[i_cmd.id]  <= 1'b0;
                            end
                        end else begin
                            r_wrap <= wrap_now;
                            r_now  <= wrap_now ? mtem_pkg::TIME_MAX : i_cmd.time_now;
                            r_prev <= i_cmd.time_now;
                        end
                    end
                end
                mtem_pkg::S_SCAN: begin
                    if (elig && better) begin
                        r_found    <= 1'b1;
                        r_best     <= r_idx;
                        r_best_exp <= r_expiry[r_idx];
                    end
                    r_idx <= r_idx + 1'b1;
                end
                mtem_pkg::S_PICK: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (due) begin
                        r_sel     <= r_best;
                        r_new_id  <= r_best;
                        r_new_cnt <= 16'd1;
                        r_dcnt    <= '0;
                        r_rem     <= '0;
                        r_quo     <= r_now - r_best_exp;
                        if (!sel_reload) begin
                            r_armed[r_best] <= 1'b0;
                            r_next[r_best]  <= 1'b0;
                        end
                    end else begin
                        r_sel <= r_cmd.id;
                        if (r_wrap) begin
                            r_next <= '0;
                        end
                    end
                end
                mtem_pkg::S_DIV: begin
                    r_rem  <= div_ge ? 32'(div_t - {1'b0, sel_period}) : div_t[31:0];
                    r_quo  <= {r_quo[30:0], div_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                end
                mtem_pkg::S_RELOAD: begin
                    r_expiry[r_sel] <= reload_sum[31:0];
                    r_next[r_sel]   <= reload_sum[32];
                    r_armed[r_sel]  <= 1'b1;
                    r_new_cnt       <= sat_cnt;
                end
                mtem_pkg::S_EMIT: begin
                    if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            r_o.fired_timer  <= 3'(r_hold_id);
                            r_o.fire_count   <= r_hold_cnt;
                            r_o.last_event   <= 1'b0;
                        end
                        r_hold_v   <= 1'b1;
                        r_hold_id  <= r_new_id;
                        r_hold_cnt <= r_new_cnt;
                    end
                end
                mtem_pkg::S_POST: begin
                    if (arm_go) begin
                        if (r_cmd.op == mtem_pkg::OP_CHANGE) begin
                            r_period[r_cmd.id] <= r_cmd.period;
                        end
                        r_expiry[r_cmd.id] <= arm_sum[31:0];
                        r_next[r_cmd.id]   <= arm_sum[32];
                        r_armed[r_cmd.id]  <= 1'b1;
                    end
                end
                mtem_pkg::S_FINISH: begin
                    if (r_hold_v && out_free) begin
                        r_o.fired_timer <= 3'(r_hold_id);
                        r_o.fire_count  <= r_hold_cnt;
                        r_o.last_event  <= 1'b1;
                        r_hold_v        <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_o;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mtem_pkg::S_IDLE |-> !r_hold_v)
        else $error("held result left behind at idle");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o.fire_count != 16'd0)
        else $error("zero fire count");

    a_reload_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mtem_pkg::S_RELOAD |=> r_armed[$past(r_sel)])
        else $error("reloaded timer not armed");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == mtem_pkg::S_IDLE && !i_empty)
        else $error("queue popped outside idle");
`endif

endmodule

[sv/multi_timer_expiry_manager.sv]
// multi_timer_expiry_manager: top level, front decoder, command queue and timer engine
// depends on mtem_pkg, mtem_front, mtem_fifo, mtem_back
//
//   channel   valid      stall      payload
//   request   i_valid    o_stall    i_in   (mtem_pkg::t_in)
//   result    o_valid    i_stall    o_out  (mtem_pkg::t_out)
//   config    i_cfg_we   -          i_cfg_wdata
//
// a request is queued whenever the queue is not full; the queue holds two commands
// stop is handled in idle; start and change period pass through post and finish; service scans and picks
// each auto-reload expiry runs the bit-serial backlog divider before the reload
// wrap handling rescans all eight timers after every expiry
// synchronous active-low reset clears all timers; results wait in an output register
module multi_timer_expiry_manager (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mtem_pkg::t_in   i_in,
    output logic            o_valid,
    input  logic            i_stall,
    output mtem_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    mtem_pkg::t_cmd cmd_in;
    mtem_pkg::t_cmd cmd_out;

    mtem_front u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    mtem_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    mtem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (empty),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule
